/* rtl/core/prc_pkg.sv */
package prc_pkg;

  // Default built depth of the capture ring.
  localparam int PRC_RING_DEPTH = 1024;

  // Widths fixed by the request and result formats.
  localparam int OP_W    = 2;
  localparam int DATA_W  = 64;
  localparam int TIME_W  = 48;
  localparam int MODE_W  = 2;
  localparam int LEN_W   = 11;

  localparam logic [LEN_W-1:0] RING_LENGTH_RESET = LEN_W'(1024);

  typedef enum logic [OP_W-1:0] {
    OP_SAMPLE          = 2'd0,
    OP_FLUSH_TICK      = 2'd1,
    OP_START_RECORDING = 2'd2,
    OP_START_FLUSHING  = 2'd3
  } op_t;

  typedef enum logic [MODE_W-1:0] {
    MODE_STANDBY   = 2'd0,
    MODE_RECORDING = 2'd1,
    MODE_FLUSHING  = 2'd2
  } mode_t;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_READ = 1'b1
  } ctl_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;       // a request is taken at this edge
    logic load_direct;  // result register takes a result without a record
    logic load_read;    // result register takes the memory read data
  } ctl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic needs_read;   // the pending request is a flush tick that reads an entry
  } dp_sts_t;

endpackage

/* rtl/core/prc_ifs.sv */
interface prc_in_if import prc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   operation;
  logic [DATA_W-1:0] sample_data;
  logic [TIME_W-1:0] sample_time;

  modport source (output valid, output operation, output sample_data,
                  output sample_time, input ready);
  modport sink   (input valid, input operation, input sample_data,
                  input sample_time, output ready);
endinterface

interface prc_out_if import prc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              has_record;
  logic [DATA_W-1:0] record_data;
  logic [TIME_W-1:0] record_time;
  logic [MODE_W-1:0] mode;
  logic [LEN_W-1:0]  entries_held;

  modport source (output valid, output has_record, output record_data,
                  output record_time, output mode, output entries_held,
                  input ready);
  modport sink   (input valid, input has_record, input record_data,
                  input record_time, input mode, input entries_held,
                  output ready);
endinterface

interface prc_cfg_if import prc_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [LEN_W-1:0] ring_length;

  modport source (output valid, output ring_length, input ready);
  modport sink   (input valid, input ring_length, output ready);
endinterface

/* rtl/core/prc_ctrl.sv */
module prc_ctrl import prc_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  input  dp_sts_t  sts,
  output ctl_cmd_t cmd
);

  ctl_state_t state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt       = state_r;
    cmd             = '0;
    in_ready        = 1'b0;
    case (state_r)
      ST_IDLE: begin
        // Take a request once the result register is free or being emptied.
        in_ready = !out_valid_r || out_ready;
        if (in_valid && in_ready) begin
          cmd.accept = 1'b1;
          if (sts.needs_read) begin
            state_nxt = ST_READ;
          end else begin
            cmd.load_direct = 1'b1;
          end
        end
      end
      ST_READ: begin
        cmd.load_read = 1'b1;
        state_nxt     = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    if (cmd.load_direct || cmd.load_read) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  assign out_valid = out_valid_r;

endmodule

/* rtl/core/prc_datapath.sv */
module prc_datapath import prc_pkg::*; #(
  parameter int RING_DEPTH = PRC_RING_DEPTH
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [OP_W-1:0]   operation,
  input  logic [DATA_W-1:0] sample_data,
  input  logic [TIME_W-1:0] sample_time,
  input  logic              cfg_valid,
  input  logic [LEN_W-1:0]  cfg_ring_length,
  input  ctl_cmd_t          cmd,
  output dp_sts_t           sts,
  output logic              has_record,
  output logic [DATA_W-1:0] record_data,
  output logic [TIME_W-1:0] record_time,
  output logic [MODE_W-1:0] mode,
  output logic [LEN_W-1:0]  entries_held
);

  localparam int AW     = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int DEPTH_W = $clog2(RING_DEPTH + 1);
  localparam int LW     = (DEPTH_W > LEN_W) ? DEPTH_W : LEN_W;

  logic [DATA_W-1:0] payload_mem [RING_DEPTH];
  logic [TIME_W-1:0] stamp_mem   [RING_DEPTH];

  logic [LEN_W-1:0]  ring_length_r;
  mode_t             mode_r, mode_nxt;
  logic [AW-1:0]     wp_r, wp_nxt;
  logic [LEN_W-1:0]  fill_r, fill_nxt;
  logic [DATA_W-1:0] rd_data_r;
  logic [TIME_W-1:0] rd_time_r;

  logic              out_has_r;
  logic [DATA_W-1:0] out_data_r;
  logic [TIME_W-1:0] out_time_r;
  logic [MODE_W-1:0] out_mode_r;
  logic [LEN_W-1:0]  out_fill_r;

  logic [LW-1:0]     len;
  logic [LW-1:0]     len_m1;
  logic [LW-1:0]     pos_inc;
  logic [LW-1:0]     pos_dec;
  logic [AW-1:0]     rd_addr;
  logic              do_write;
  op_t               op;

  assign op = op_t'(operation);

  // Length in use: zero acts as one, anything above the built depth is clipped.
  always_comb begin
    if (ring_length_r == '0) begin
      len = LW'(1);
    end else if (LW'(ring_length_r) > LW'(RING_DEPTH)) begin
      len = LW'(RING_DEPTH);
    end else begin
      len = LW'(ring_length_r);
    end
    len_m1  = len - LW'(1);
    pos_inc = LW'(wp_r) + LW'(1);
    pos_dec = LW'(wp_r) - LW'(1);
  end

  always_comb begin
    mode_nxt       = mode_r;
    wp_nxt         = wp_r;
    fill_nxt       = fill_r;
    do_write       = 1'b0;
    sts.needs_read = 1'b0;
    rd_addr        = '0;
    case (op)
      OP_SAMPLE: begin
        if (mode_r == MODE_RECORDING) begin
          do_write = 1'b1;
          wp_nxt   = (pos_inc >= len) ? '0 : pos_inc[AW-1:0];
          if (LW'(fill_r) < len) begin
            fill_nxt = fill_r + LEN_W'(1);
          end
        end
      end
      OP_FLUSH_TICK: begin
        if (mode_r == MODE_FLUSHING) begin
          if (fill_r != '0) begin
            sts.needs_read = 1'b1;
            if (wp_r == '0 || pos_dec > len_m1) begin
              rd_addr = len_m1[AW-1:0];
            end else begin
              rd_addr = pos_dec[AW-1:0];
            end
            wp_nxt   = rd_addr;
            fill_nxt = fill_r - LEN_W'(1);
          end else begin
            mode_nxt = MODE_STANDBY;
          end
        end
      end
      OP_START_RECORDING: begin
        if (mode_r == MODE_FLUSHING) begin
          wp_nxt   = '0;
          fill_nxt = '0;
        end
        mode_nxt = MODE_RECORDING;
      end
      OP_START_FLUSHING: begin
        mode_nxt = MODE_FLUSHING;
      end
      default: begin
        mode_nxt = mode_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ring_length_r <= RING_LENGTH_RESET;
      mode_r        <= MODE_STANDBY;
      wp_r          <= '0;
      fill_r        <= '0;
    end else begin
      if (cfg_valid) begin
        ring_length_r <= cfg_ring_length;
      end
      if (cmd.accept) begin
        mode_r <= mode_nxt;
        wp_r   <= wp_nxt;
        fill_r <= fill_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept && do_write) begin
      payload_mem[wp_r] <= sample_data;
      stamp_mem[wp_r]   <= sample_time;
    end
    if (cmd.accept && sts.needs_read) begin
      rd_data_r <= payload_mem[rd_addr];
      rd_time_r <= stamp_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_direct) begin
      out_has_r  <= 1'b0;
      out_data_r <= '0;
      out_time_r <= '0;
      out_mode_r <= mode_nxt;
      out_fill_r <= fill_nxt;
    end else if (cmd.load_read) begin
      out_has_r  <= 1'b1;
      out_data_r <= rd_data_r;
      out_time_r <= rd_time_r;
      out_mode_r <= mode_r;
      out_fill_r <= fill_r;
    end
  end

  assign has_record   = out_has_r;
  assign record_data  = out_data_r;
  assign record_time  = out_time_r;
  assign mode         = out_mode_r;
  assign entries_held = out_fill_r;

endmodule

/* rtl/core/pretrigger_ring_capture.sv */
// Pre-trigger capture ring. While recording, every sample request stores its
// 64-bit payload and 48-bit timestamp in a RING_DEPTH-entry memory at a write
// index that wraps at the configured ring length; the fill count saturates at
// that length. In flushing mode each flush tick reads back the newest entry
// not yet flushed and lowers the fill count, and a flush tick on an empty
// ring returns the block to standby. Every request gives exactly one result
// carrying the mode and fill count after it. Requests that do not read the
// memory can follow back to back while the result register is being drained.
// A flush tick that returns a record goes through the registered read port
// of the ring memory; no request is taken until its result is loaded. A new
// request is taken only while the result register is empty or its result is
// being taken in the same cycle. The ring length may be written at any time
// the block is idle; the configuration port is always ready.
module pretrigger_ring_capture import prc_pkg::*; #(
  parameter int RING_DEPTH = PRC_RING_DEPTH
) (
  input  logic       clk,
  input  logic       rst_n,
  prc_in_if.sink     in_chan,
  prc_out_if.source  out_chan,
  prc_cfg_if.sink    cfg_chan
);

  ctl_cmd_t cmd;
  dp_sts_t  sts;

  // The ring length register never stalls a write.
  assign cfg_chan.ready = 1'b1;

  // The controller sequences the handshakes and the memory read latency.
  prc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_chan.valid),
    .in_ready  (in_chan.ready),
    .out_valid (out_chan.valid),
    .out_ready (out_chan.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // The datapath holds the mode, write index, fill count, ring memory and
  // the result register.
  prc_datapath #(
    .RING_DEPTH (RING_DEPTH)
  ) u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .operation       (in_chan.operation),
    .sample_data     (in_chan.sample_data),
    .sample_time     (in_chan.sample_time),
    .cfg_valid       (cfg_chan.valid),
    .cfg_ring_length (cfg_chan.ring_length),
    .cmd             (cmd),
    .sts             (sts),
    .has_record      (out_chan.has_record),
    .record_data     (out_chan.record_data),
    .record_time     (out_chan.record_time),
    .mode            (out_chan.mode),
    .entries_held    (out_chan.entries_held)
  );

`ifndef SYNTHESIS
  // A request is never taken while a stalled result would be overwritten.
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_chan.valid && in_chan.ready) |-> (!out_chan.valid || out_chan.ready))
    else $error("request accepted over a stalled result");

  // A flush tick that reads the ring presents its result once the memory read
  // register and then the result register have been loaded.
  assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.accept && sts.needs_read) |-> ##2 (out_chan.valid && out_chan.has_record))
    else $error("flush read did not produce a record");

  // A record is only ever produced while flushing.
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_chan.valid && out_chan.has_record) |->
      (out_chan.mode == MODE_FLUSHING))
    else $error("record delivered outside flushing mode");

  // No request is taken while a memory read is still in flight.
  assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_read |-> !in_chan.ready)
    else $error("request accepted during a ring read");
`endif

endmodule
